### design/vsop_pkg.sv
// Shared types and constants for the voxel sphere occupancy painter.
// No dependencies; imported by vsop_rule, vsop_grid and the top level.
`default_nettype none

package vsop_pkg;

	localparam int KIND_W    = 3;
	localparam int BIN_W     = 8;
	localparam int RAD_W     = 14;
	localparam int EXT_W     = 7;
	localparam int CLS_W     = 3;
	localparam int CNT_W     = 12;
	localparam int VOL_W     = 19;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 14;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_PLACE_ATOM   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PLACE_WATER  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EXPAND_ATOM  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXPAND_WATER = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMOVE_ATOM  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REMOVE_WATER = 3'd5;

	// cell classes
	localparam logic [CLS_W-1:0] CLS_EMPTY   = 3'd0;
	localparam logic [CLS_W-1:0] CLS_ACENTRE = 3'd1;
	localparam logic [CLS_W-1:0] CLS_AAREA   = 3'd2;
	localparam logic [CLS_W-1:0] CLS_VOLUME  = 3'd3;
	localparam logic [CLS_W-1:0] CLS_WCENTRE = 3'd4;
	localparam logic [CLS_W-1:0] CLS_WAREA   = 3'd5;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_X_EXTENT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_Y_EXTENT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_Z_EXTENT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUTER_SQ = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WATER_SQ = 3'd4;

	localparam logic [EXT_W-1:0] RST_EXTENT   = 7'd64;
	localparam logic [RAD_W-1:0] RST_OUTER_SQ = 14'd2304;
	localparam logic [RAD_W-1:0] RST_WATER_SQ = 14'd591;

	typedef struct packed {
		logic             wr;
		logic [CLS_W-1:0] cls;
		logic             chg;
		logic             vol;
	} cell_upd_t;

endpackage

`default_nettype wire

### design/voxel_sphere_occupancy_painter.sv
// Voxel sphere painter: one voxel read-modify-write per cycle over the sphere box.
// Expand/remove: scan of the (2r+1)^3 offsets of the box, then a drain step (removes
// then also read and rewrite the centre), r = reach of the radius, capped at MAX_REACH;
// place: centre read and write; bad centre or unused kind: straight to the finish step.
// Rate is set by the single grid memory port pair. Results cannot be stalled: done strobes
// for one cycle. After reset the whole grid is cleared, busy held high.
`default_nettype none

module voxel_sphere_occupancy_painter #(
	parameter int GRID_DIM  = 64,
	parameter int MAX_REACH = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [vsop_pkg::KIND_W-1:0]    kind,
	input  logic [vsop_pkg::BIN_W-1:0]     x_bin,
	input  logic [vsop_pkg::BIN_W-1:0]     y_bin,
	input  logic [vsop_pkg::BIN_W-1:0]     z_bin,
	input  logic [vsop_pkg::RAD_W-1:0]     inner_radius_sq_q8,
	input  logic                           wr_en,
	input  logic [vsop_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [vsop_pkg::CFG_W-1:0]     wr_data,
	output logic                           done,
	output logic                           status,
	output logic [vsop_pkg::CNT_W-1:0]     changed_cells,
	output logic [vsop_pkg::VOL_W-1:0]     volume_total
);
	import vsop_pkg::*;

	localparam int AW    = $clog2(GRID_DIM);
	localparam int ABITS = 3 * AW;
	localparam int RW    = $clog2(MAX_REACH + 1);
	localparam int PW    = ((AW > RW) ? AW : RW) + 2;
	localparam int DW    = 2 * RW + 2;
	localparam int CMPW  = (DW + 8 > RAD_W) ? DW + 8 : RAD_W;
	localparam int LW    = BIN_W + 1;
	localparam logic [LW-1:0] GRID_LIM = LW'(GRID_DIM);
	localparam logic signed [RW:0] ONE_OFF = (RW + 1)'(1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_CREAD, S_CWRITE, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [EXT_W-1:0] xext_q, yext_q, zext_q;
	logic [RAD_W-1:0] outer_q, water_q;

	// request context
	logic [KIND_W-1:0] kind_q;
	logic [AW-1:0]     xc_q, yc_q, zc_q;
	logic [RAD_W-1:0]  rad_q, inner_q;
	logic [RW-1:0]     reach_q;

	logic signed [RW:0] dx_q, dy_q, dz_q;
	logic [ABITS-1:0]   clr_q;
	logic [CNT_W-1:0]   cnt_chg_q, cnt_vol_q;
	logic [VOL_W-1:0]   vol_q;
	logic               st_q, done_q;

	logic               vld_s1, inner_s1;
	logic [ABITS-1:0]   addr_s1;

	function automatic logic [LW-1:0] eff_ext(input logic [EXT_W-1:0] e);
		eff_ext = (LW'(e) > GRID_LIM) ? GRID_LIM : LW'(e);
	endfunction

	logic [LW-1:0] effx, effy, effz;
	logic          in_grid, kind_ok, is_place, is_atom_rad;
	logic [RAD_W-1:0] rsel, inner_cl;
	logic [RW-1:0]    reach_c;

	assign effx = eff_ext(xext_q);
	assign effy = eff_ext(yext_q);
	assign effz = eff_ext(zext_q);

	assign in_grid = (LW'(x_bin) < effx) && (LW'(y_bin) < effy) && (LW'(z_bin) < effz);
	assign kind_ok = (kind <= KIND_REMOVE_WATER);
	assign is_place = (kind == KIND_PLACE_ATOM) || (kind == KIND_PLACE_WATER);
	assign is_atom_rad = (kind == KIND_EXPAND_ATOM) || (kind == KIND_REMOVE_ATOM);
	assign rsel = is_atom_rad ? outer_q : water_q;
	assign inner_cl = (inner_radius_sq_q8 > outer_q) ? outer_q : inner_radius_sq_q8;

	// reach: largest k <= MAX_REACH with k^2 * 256 <= radius; compares are monotone in k
	always_comb begin
		reach_c = '0;
		for (int k = 1; k <= MAX_REACH; k++) begin
			if (CMPW'(k * k * 256) <= CMPW'(rsel)) begin
				reach_c = RW'(k);
			end
		end
	end

	// scan address and distance for the current offsets
	logic signed [RW:0]   r_s;
	logic signed [PW-1:0] ci, cj, ck;
	logic signed [DW-1:0] sqx, sqy, sqz;
	logic [DW-1:0]        d2;
	logic [CMPW-1:0]      d2s;
	logic                 in_box, in_outer, in_inner, last_off;
	logic [ABITS-1:0]     scan_addr, centre_addr, raddr, waddr;
	logic [CLS_W-1:0]     rdata, wdata;
	logic                 we;
	cell_upd_t            upd;

	assign r_s = $signed({1'b0, reach_q});
	assign ci = $signed(PW'(xc_q)) + PW'(dx_q);
	assign cj = $signed(PW'(yc_q)) + PW'(dy_q);
	assign ck = $signed(PW'(zc_q)) + PW'(dz_q);

	assign in_box = (ci >= 0) && (ci < $signed(PW'(effx)))
		&& (cj >= 0) && (cj < $signed(PW'(effy)))
		&& (ck >= 0) && (ck < $signed(PW'(effz)));

	assign sqx = dx_q * dx_q;
	assign sqy = dy_q * dy_q;
	assign sqz = dz_q * dz_q;
	assign d2 = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
	assign d2s = CMPW'({d2, 8'b0});
	assign in_outer = (d2s <= CMPW'(rad_q));
	assign in_inner = (d2s <= CMPW'(inner_q));
	assign last_off = (dx_q == r_s) && (dy_q == r_s) && (dz_q == r_s);

	assign scan_addr = {ci[AW-1:0], cj[AW-1:0], ck[AW-1:0]};
	assign centre_addr = {xc_q, yc_q, zc_q};
	assign raddr = (state_q == S_CREAD) ? centre_addr : scan_addr;

	vsop_rule u_rule (
		.kind     (kind_q),
		.centre   (state_q == S_CWRITE),
		.paint    (vld_s1),
		.in_inner (inner_s1),
		.old      (rdata),
		.upd      (upd)
	);

	always_comb begin
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = CLS_EMPTY;
		end else begin
			we    = upd.wr;
			waddr = (state_q == S_CWRITE) ? centre_addr : addr_s1;
			wdata = upd.cls;
		end
	end

	vsop_grid #(.ABITS(ABITS)) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// volume update: atom removes subtract with floor at zero, other kinds add with ceiling
	logic [VOL_W:0]   vsum;
	logic [VOL_W-1:0] vol_nx;

	assign vsum = {1'b0, vol_q} + (VOL_W + 1)'(cnt_vol_q);

	always_comb begin
		if (kind_q == KIND_REMOVE_ATOM) begin
			vol_nx = (VOL_W'(cnt_vol_q) > vol_q) ? '0 : vol_q - VOL_W'(cnt_vol_q);
		end else begin
			vol_nx = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xext_q  <= RST_EXTENT;
			yext_q  <= RST_EXTENT;
			zext_q  <= RST_EXTENT;
			outer_q <= RST_OUTER_SQ;
			water_q <= RST_WATER_SQ;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_X_EXTENT: xext_q  <= wr_data[EXT_W-1:0];
				REG_Y_EXTENT: yext_q  <= wr_data[EXT_W-1:0];
				REG_Z_EXTENT: zext_q  <= wr_data[EXT_W-1:0];
				REG_OUTER_SQ: outer_q <= wr_data[RAD_W-1:0];
				REG_WATER_SQ: water_q <= wr_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			dz_q      <= '0;
			cnt_chg_q <= '0;
			cnt_vol_q <= '0;
			vol_q     <= '0;
			st_q      <= 1'b0;
			done_q    <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == S_SCAN) && in_box && in_outer;
			if (upd.chg) begin
				cnt_chg_q <= cnt_chg_q + CNT_W'(1);
			end
			if (upd.vol) begin
				cnt_vol_q <= cnt_vol_q + CNT_W'(1);
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ABITS'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cnt_chg_q <= '0;
						cnt_vol_q <= '0;
						st_q      <= kind_ok && !in_grid;
						dx_q      <= -$signed({1'b0, reach_c});
						dy_q      <= -$signed({1'b0, reach_c});
						dz_q      <= -$signed({1'b0, reach_c});
						if (!kind_ok || !in_grid) begin
							state_q <= S_FIN;
						end else if (is_place) begin
							state_q <= S_CREAD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// z fastest, then y, then x
					if (dz_q == r_s) begin
						dz_q <= -r_s;
						if (dy_q == r_s) begin
							dy_q <= -r_s;
							dx_q <= dx_q + ONE_OFF;
						end else begin
							dy_q <= dy_q + ONE_OFF;
						end
					end else begin
						dz_q <= dz_q + ONE_OFF;
					end
					if (last_off) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last painted cell is written this cycle; centre read follows for removes
					if (kind_q == KIND_REMOVE_ATOM || kind_q == KIND_REMOVE_WATER) begin
						state_q <= S_CREAD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_CREAD: state_q <= S_CWRITE;
				S_CWRITE: state_q <= S_FIN;
				S_FIN: begin
					vol_q   <= vol_nx;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			kind_q  <= kind;
			xc_q    <= x_bin[AW-1:0];
			yc_q    <= y_bin[AW-1:0];
			zc_q    <= z_bin[AW-1:0];
			rad_q   <= rsel;
			inner_q <= inner_cl;
			reach_q <= reach_c;
		end
		addr_s1  <= scan_addr;
		inner_s1 <= in_inner;
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = st_q;
	assign changed_cells = cnt_chg_q;
	assign volume_total  = vol_q;

endmodule

`default_nettype wire

### design/vsop_rule.sv
// Per-cell update rule: new class, change flag and volume step for one voxel.
// Depends on vsop_pkg.
`default_nettype none

module vsop_rule (
	input  logic [vsop_pkg::KIND_W-1:0] kind,
	input  logic                        centre,
	input  logic                        paint,
	input  logic                        in_inner,
	input  logic [vsop_pkg::CLS_W-1:0]  old,
	output vsop_pkg::cell_upd_t         upd
);
	import vsop_pkg::*;

	always_comb begin
		upd = '0;
		if (centre) begin
			unique case (kind)
				KIND_PLACE_ATOM: begin
					upd.wr  = 1'b1;
					upd.cls = CLS_ACENTRE;
					upd.chg = (old != CLS_ACENTRE);
					upd.vol = (old != CLS_AAREA);
				end
				KIND_PLACE_WATER: begin
					upd.wr  = 1'b1;
					upd.cls = CLS_WCENTRE;
					upd.chg = (old != CLS_WCENTRE);
				end
				KIND_REMOVE_ATOM: begin
					upd.wr  = 1'b1;
					upd.cls = CLS_EMPTY;
					upd.chg = (old != CLS_EMPTY);
					upd.vol = 1'b1;
				end
				KIND_REMOVE_WATER: begin
					upd.wr  = 1'b1;
					upd.cls = CLS_EMPTY;
					upd.chg = (old != CLS_EMPTY);
				end
				default: ;
			endcase
		end else if (paint) begin
			unique case (kind)
				KIND_EXPAND_ATOM: begin
					if (in_inner) begin
						if (old == CLS_EMPTY || old == CLS_VOLUME) begin
							upd.wr  = 1'b1;
							upd.cls = CLS_AAREA;
							upd.chg = 1'b1;
							upd.vol = (old == CLS_EMPTY);
						end
					end else if (old == CLS_EMPTY) begin
						upd.wr  = 1'b1;
						upd.cls = CLS_VOLUME;
						upd.chg = 1'b1;
						upd.vol = 1'b1;
					end
				end
				KIND_EXPAND_WATER: begin
					if (old == CLS_EMPTY) begin
						upd.wr  = 1'b1;
						upd.cls = CLS_WAREA;
						upd.chg = 1'b1;
					end
				end
				KIND_REMOVE_ATOM: begin
					if (old == CLS_AAREA || old == CLS_VOLUME) begin
						upd.wr  = 1'b1;
						upd.cls = CLS_EMPTY;
						upd.chg = 1'b1;
						upd.vol = 1'b1;
					end
				end
				KIND_REMOVE_WATER: begin
					if (old == CLS_WAREA) begin
						upd.wr  = 1'b1;
						upd.cls = CLS_EMPTY;
						upd.chg = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/vsop_grid.sv
// Voxel class memory: one write port, one read port with registered data.
// Depends on vsop_pkg.
`default_nettype none

module vsop_grid #(
	parameter int ABITS = 18
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ABITS-1:0]           waddr,
	input  logic [vsop_pkg::CLS_W-1:0] wdata,
	input  logic [ABITS-1:0]           raddr,
	output logic [vsop_pkg::CLS_W-1:0] rdata
);
	import vsop_pkg::*;

	localparam int DEPTH = 1 << ABITS;

	logic [CLS_W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### dv/voxel_sphere_occupancy_painter_tb.sv
// Self-checking testbench for voxel_sphere_occupancy_painter: directed and random requests,
// predicted by an in-bench voxel grid model held in a small scoreboard class.
// Depends on vsop_pkg and the painter RTL only.
`timescale 1ns / 100ps

module voxel_sphere_occupancy_painter_tb;
	import vsop_pkg::*;

	localparam int GRID_DIM   = 64;
	localparam int MAX_REACH  = 7;
	localparam int GRID_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
	localparam int unsigned VOL_MAX = (1 << VOL_W) - 1;
	localparam int unsigned RAD_MAX = (1 << RAD_W) - 1;

	// kinds the block ignores
	localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

	typedef struct {
		logic             status;
		logic [CNT_W-1:0] changed;
		logic [VOL_W-1:0] volume;
	} paint_report_t;

	class occupancy_scoreboard;
		logic [CLS_W-1:0] cell_cls [GRID_CELLS];
		int unsigned      occupied;
		int unsigned      extent [3];
		int unsigned      outer_sq;
		int unsigned      water_sq;
		paint_report_t    report_q [$];
		int unsigned      failures;

		function new();
			foreach (cell_cls[n]) cell_cls[n] = CLS_EMPTY;
			occupied = 0;
			foreach (extent[a]) extent[a] = RST_EXTENT;
			outer_sq = RST_OUTER_SQ;
			water_sq = RST_WATER_SQ;
			failures = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_X_EXTENT: extent[0] = data[EXT_W-1:0];
				REG_Y_EXTENT: extent[1] = data[EXT_W-1:0];
				REG_Z_EXTENT: extent[2] = data[EXT_W-1:0];
				REG_OUTER_SQ: outer_sq = data[RAD_W-1:0];
				REG_WATER_SQ: water_sq = data[RAD_W-1:0];
				default: ;
			endcase
		endfunction

		function int eff_extent(int a);
			return extent[a] > GRID_DIM ? GRID_DIM : int'(extent[a]);
		endfunction

		function int reach_of(int unsigned rsq);
			int r;
			r = 0;
			while (r < MAX_REACH && (r + 1) * (r + 1) * 256 <= int'(rsq)) r++;
			return r;
		endfunction

		function int cell_index(int i, int j, int q);
			return (i * GRID_DIM + j) * GRID_DIM + q;
		endfunction

		function void add_volume(int unsigned n);
			occupied = (occupied + n > VOL_MAX) ? VOL_MAX : occupied + n;
		endfunction

		function void drop_volume(int unsigned n);
			occupied = (n > occupied) ? 0 : occupied - n;
		endfunction

		// one pass over the clipped box around the centre
		function int unsigned paint_sphere(logic [KIND_W-1:0] k, int x, int y, int z,
				int unsigned inner, int unsigned radius);
			int          r, i, j, q, idx;
			int unsigned d2, changed, added, removed;
			r = reach_of(radius);
			changed = 0;
			added = 0;
			removed = 0;
			for (i = x - r; i <= x + r; i++) begin
				if (i < 0 || i >= eff_extent(0)) continue;
				for (j = y - r; j <= y + r; j++) begin
					if (j < 0 || j >= eff_extent(1)) continue;
					for (q = z - r; q <= z + r; q++) begin
						if (q < 0 || q >= eff_extent(2)) continue;
						idx = cell_index(i, j, q);
						d2 = ((x - i) * (x - i) + (y - j) * (y - j) + (z - q) * (z - q)) * 256;
						if (d2 > radius) continue;
						case (k)
							KIND_EXPAND_ATOM: begin
								if (d2 <= inner) begin
									if (cell_cls[idx] == CLS_EMPTY || cell_cls[idx] == CLS_VOLUME) begin
										if (cell_cls[idx] == CLS_EMPTY) added++;
										cell_cls[idx] = CLS_AAREA;
										changed++;
									end
								end else if (cell_cls[idx] == CLS_EMPTY) begin
									cell_cls[idx] = CLS_VOLUME;
									added++;
									changed++;
								end
							end
							KIND_EXPAND_WATER: begin
								if (cell_cls[idx] == CLS_EMPTY) begin
									cell_cls[idx] = CLS_WAREA;
									changed++;
								end
							end
							KIND_REMOVE_ATOM: begin
								if (cell_cls[idx] == CLS_AAREA || cell_cls[idx] == CLS_VOLUME) begin
									cell_cls[idx] = CLS_EMPTY;
									removed++;
									changed++;
								end
							end
							default: begin
								if (cell_cls[idx] == CLS_WAREA) begin
									cell_cls[idx] = CLS_EMPTY;
									changed++;
								end
							end
						endcase
					end
				end
			end
			add_volume(added);
			drop_volume(removed);
			return changed;
		endfunction

		function void note_request(logic [KIND_W-1:0] k, logic [BIN_W-1:0] x,
				logic [BIN_W-1:0] y, logic [BIN_W-1:0] z, logic [RAD_W-1:0] inner);
			paint_report_t rep;
			int unsigned   in_c, changed;
			int            ctr;
			rep.status = 1'b0;
			changed = 0;
			in_c = (inner > outer_sq) ? outer_sq : inner;
			if (k <= KIND_REMOVE_WATER) begin
				if (x >= eff_extent(0) || y >= eff_extent(1) || z >= eff_extent(2)) begin
					rep.status = 1'b1;
				end else begin
					ctr = cell_index(x, y, z);
					case (k)
						KIND_PLACE_ATOM: begin
							if (cell_cls[ctr] != CLS_AAREA) add_volume(1);
							if (cell_cls[ctr] != CLS_ACENTRE) changed = 1;
							cell_cls[ctr] = CLS_ACENTRE;
						end
						KIND_PLACE_WATER: begin
							if (cell_cls[ctr] != CLS_WCENTRE) changed = 1;
							cell_cls[ctr] = CLS_WCENTRE;
						end
						KIND_EXPAND_ATOM:  changed = paint_sphere(k, x, y, z, in_c, outer_sq);
						KIND_EXPAND_WATER: changed = paint_sphere(k, x, y, z, 0, water_sq);
						KIND_REMOVE_ATOM: begin
							changed = paint_sphere(k, x, y, z, 0, outer_sq);
							if (cell_cls[ctr] != CLS_EMPTY) changed++;
							cell_cls[ctr] = CLS_EMPTY;
							drop_volume(1);
						end
						default: begin
							changed = paint_sphere(k, x, y, z, 0, water_sq);
							if (cell_cls[ctr] != CLS_EMPTY) changed++;
							cell_cls[ctr] = CLS_EMPTY;
						end
					endcase
				end
			end
			rep.changed = changed[CNT_W-1:0];
			rep.volume = occupied[VOL_W-1:0];
			report_q.insert(report_q.size(), rep);
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10) $display("%0t ns mismatch: %s", $time, msg);
		endfunction

		function void check_result(logic st, logic [CNT_W-1:0] cc, logic [VOL_W-1:0] vt);
			paint_report_t rep;
			if (report_q.size() == 0) begin
				flag($sformatf("result with no request outstanding: status %0d changed %0d volume %0d",
					st, cc, vt));
			end else begin
				rep = report_q.pop_front();
				if (st !== rep.status)
					flag($sformatf("status: expected %0d, got %0d", rep.status, st));
				if (cc !== rep.changed)
					flag($sformatf("changed_cells: expected %0d, got %0d", rep.changed, cc));
				if (vt !== rep.volume)
					flag($sformatf("volume_total: expected %0d, got %0d", rep.volume, vt));
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [KIND_W-1:0]    kind;
	logic [BIN_W-1:0]     x_bin, y_bin, z_bin;
	logic [RAD_W-1:0]     inner_radius_sq_q8;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 done;
	logic                 status;
	logic [CNT_W-1:0]     changed_cells;
	logic [VOL_W-1:0]     volume_total;

	occupancy_scoreboard sb = new();
	int                  idle_pct;
	logic [23:0]         atom_sites [$];
	logic [23:0]         water_sites [$];

	voxel_sphere_occupancy_painter #(
		.GRID_DIM (GRID_DIM),
		.MAX_REACH(MAX_REACH)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.kind              (kind),
		.x_bin             (x_bin),
		.y_bin             (y_bin),
		.z_bin             (z_bin),
		.inner_radius_sq_q8(inner_radius_sq_q8),
		.wr_en             (wr_en),
		.wr_index          (wr_index),
		.wr_data           (wr_data),
		.done              (done),
		.status            (status),
		.changed_cells     (changed_cells),
		.volume_total      (volume_total)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) sb.write_reg(wr_index, wr_data);
			if (start && !busy) sb.note_request(kind, x_bin, y_bin, z_bin, inner_radius_sq_q8);
			if (done) sb.check_result(status, changed_cells, volume_total);
		end
	end

	// request is taken at the first edge with busy low; start stays up for back-to-back
	task automatic issue(input logic [KIND_W-1:0] k, input int x, input int y, input int z,
			input int unsigned inner);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		x_bin <= BIN_W'(x);
		y_bin <= BIN_W'(y);
		z_bin <= BIN_W'(z);
		inner_radius_sq_q8 <= RAD_W'(inner);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.report_q.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(input int unsigned xe, input int unsigned ye, input int unsigned ze,
			input int unsigned osq, input int unsigned wsq);
		logic [REG_IDX_W-1:0] idx_list [5];
		int unsigned          vals [5];
		idx_list = '{REG_X_EXTENT, REG_Y_EXTENT, REG_Z_EXTENT, REG_OUTER_SQ, REG_WATER_SQ};
		vals = '{xe, ye, ze, osq, wsq};
		for (int n = 0; n < 5; n++) begin
			wr_en <= 1'b1;
			wr_index <= idx_list[n];
			wr_data <= CFG_W'(vals[n]);
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// centres mostly hug the low and high corners so spheres overlap and clip
	function automatic int axis_pick(int a);
		int lim;
		lim = sb.eff_extent(a);
		if (lim == 0 || $urandom_range(0, 24) == 0) return $urandom_range(0, 255);
		if ($urandom_range(0, 1) == 1) return $urandom_range(0, (lim < 10 ? lim : 10) - 1);
		return lim - 1 - $urandom_range(0, (lim < 6 ? lim : 6) - 1);
	endfunction

	function automatic int unsigned rand_inner();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(0, RAD_MAX);
			2: return $urandom_range(0, sb.outer_sq);
			default: return sb.outer_sq;
		endcase
	endfunction

	task automatic run_phase(input int n, input int pct);
		int          sent, roll, pick, cx, cy, cz;
		logic [23:0] site;
		idle_pct = pct;
		sent = 0;
		while (sent < n) begin
			roll = $urandom_range(0, 99);
			cx = axis_pick(0);
			cy = axis_pick(1);
			cz = axis_pick(2);
			if (roll < 40) begin
				issue(KIND_PLACE_ATOM, cx, cy, cz, rand_inner());
				issue(KIND_EXPAND_ATOM, cx, cy, cz, rand_inner());
				site = {cx[7:0], cy[7:0], cz[7:0]};
				atom_sites.insert(atom_sites.size(), site);
				sent += 2;
			end else if (roll < 65) begin
				issue(KIND_PLACE_WATER, cx, cy, cz, rand_inner());
				issue(KIND_EXPAND_WATER, cx, cy, cz, rand_inner());
				site = {cx[7:0], cy[7:0], cz[7:0]};
				water_sites.insert(water_sites.size(), site);
				sent += 2;
			end else if (roll < 85) begin
				if ($urandom_range(0, 1) == 0 && atom_sites.size() > 0) begin
					pick = $urandom_range(0, atom_sites.size() - 1);
					site = atom_sites[pick];
					atom_sites.delete(pick);
					issue(KIND_REMOVE_ATOM, site[23:16], site[15:8], site[7:0], rand_inner());
				end else if (water_sites.size() > 0) begin
					pick = $urandom_range(0, water_sites.size() - 1);
					site = water_sites[pick];
					water_sites.delete(pick);
					issue(KIND_REMOVE_WATER, site[23:16], site[15:8], site[7:0], rand_inner());
				end else begin
					issue(KIND_REMOVE_ATOM, cx, cy, cz, rand_inner());
				end
				sent++;
			end else begin
				issue(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, RAD_MAX));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_PLACE_ATOM;
		x_bin = '0;
		y_bin = '0;
		z_bin = '0;
		inner_radius_sq_q8 = '0;
		wr_en = 1'b0;
		wr_index = REG_X_EXTENT;
		wr_data = '0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// grid clear runs with busy high
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed, reset settings: reach 3 outer, reach 1 water
		issue(KIND_REMOVE_ATOM, 5, 5, 5, 0);       // volume already zero
		issue(KIND_SPARE_6, 1, 2, 3, 100);
		issue(KIND_SPARE_7, 255, 255, 255, RAD_MAX);
		issue(KIND_PLACE_ATOM, 0, 0, 0, 0);
		issue(KIND_PLACE_ATOM, 0, 0, 0, 0);        // same centre again
		issue(KIND_EXPAND_ATOM, 0, 0, 0, 0);       // corner, box clipped
		issue(KIND_REMOVE_ATOM, 0, 0, 0, 0);
		issue(KIND_PLACE_ATOM, 63, 63, 63, 0);
		issue(KIND_EXPAND_ATOM, 63, 63, 63, RAD_MAX); // inner clamps to outer
		issue(KIND_PLACE_ATOM, 62, 63, 63, 0);     // lands on atom area
		issue(KIND_EXPAND_WATER, 63, 63, 61, 0);
		issue(KIND_PLACE_WATER, 10, 20, 30, 0);
		issue(KIND_EXPAND_WATER, 10, 20, 30, 0);
		issue(KIND_PLACE_WATER, 10, 20, 30, 0);
		issue(KIND_REMOVE_WATER, 10, 20, 30, 0);
		issue(KIND_REMOVE_WATER, 63, 63, 63, 0);   // clears an atom centre
		issue(KIND_PLACE_ATOM, 64, 0, 0, 0);
		issue(KIND_EXPAND_ATOM, 0, 128, 0, 500);
		issue(KIND_REMOVE_ATOM, 0, 0, 255, 0);
		issue(KIND_EXPAND_WATER, 200, 64, 100, 0);
		issue(KIND_PLACE_ATOM, 32, 32, 32, 0);
		issue(KIND_EXPAND_ATOM, 32, 32, 32, 1024);
		issue(KIND_REMOVE_ATOM, 32, 32, 32, 0);
		issue(KIND_REMOVE_ATOM, 62, 63, 63, 0);
		issue(KIND_REMOVE_ATOM, 63, 63, 63, 0);

		settle();
		load_regs(127, 64, 40, 1000, 2304);
		run_phase(45, 0);
		settle();
		load_regs(20, 33, 64, 2304, 591);
		run_phase(45, 77);
		settle();
		load_regs(64, 1, 64, 0, 0);                // zero radii touch the centre only
		run_phase(25, 0);
		settle();
		load_regs(0, 64, 64, 2000, 591);           // zero extent: every centre outside
		run_phase(8, 27);
		settle();
		load_regs(64, 64, 64, RAD_MAX, 12544);     // widest boxes, keep this phase short
		run_phase(12, 27);
		settle();
		load_regs(30, 30, 30, 3000, 1500);
		run_phase(35, 27);

		start <= 1'b0;
		@(posedge clk);
		while (sb.report_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0) begin
			$display("voxel_sphere_occupancy_painter_tb: PASS");
		end else begin
			$display("voxel_sphere_occupancy_painter_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("voxel_sphere_occupancy_painter_tb: FAIL");
		$finish;
	end

endmodule
